// ===== rtl/aswt_pkg.sv =====
// Shared types and constants for the ARQ send window tracker.
// No dependencies; imported by aswt_cell and arq_send_window_tracker.
`default_nettype none

package aswt_pkg;

    // Window geometry
    localparam int WINDOW_SLOTS = 5;
    localparam int SEQ_W        = 16;
    localparam int CNT_W        = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int DROP_W       = $clog2(WINDOW_SLOTS + 1);

    typedef logic [SEQ_W-1:0] t_seq;
    typedef logic [1:0]       t_cmd;
    typedef logic [1:0]       t_kind;

    // Slot markers and limits
    localparam t_seq SLOT_OPEN      = 16'hFFFF;
    localparam t_seq SLOT_ACKED     = 16'hFFFE;
    localparam t_seq ACK_MAX        = 16'hFFFF;
    localparam t_seq LAST_SEQ_RESET = 16'hFFFD;

    // Command codes
    localparam t_cmd CMD_SEND = 2'd0;
    localparam t_cmd CMD_ACK  = 2'd1;
    localparam t_cmd CMD_TICK = 2'd2;
    localparam t_cmd CMD_NONE = 2'd3;

    // Result kinds
    localparam t_kind KIND_SENT   = 2'd0;
    localparam t_kind KIND_FULL   = 2'd1;
    localparam t_kind KIND_ACKED  = 2'd2;
    localparam t_kind KIND_RESEND = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/aswt_cell.sv =====
// One window slot of the rotating slot chain.
// Depends on aswt_pkg for the slot type and the open-slot marker.
`default_nettype none

module aswt_cell (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_shift,
    input  aswt_pkg::t_seq i_slot,
    output aswt_pkg::t_seq o_slot
);
    import aswt_pkg::*;

    t_seq r_slot;

    // Take the neighbour's slot on every shift cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_OPEN;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

// ===== rtl/arq_send_window_tracker.sv =====
// Top level of the ARQ send window tracker: slot chain, head processing, sequencer.
// Depends on aswt_pkg and aswt_cell.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+---------------------------
//   request  | i_command, i_seq_number, i_final_packet      | start high while busy low
//   result   | o_kind, o_seq_out, o_all_acked, o_last       | o_valid for one cycle
//
// The slots rotate through a chain of WINDOW_SLOTS cells, one position per cycle, and
// the head cell is examined as it passes. Send and tick stay busy for the pass and a report
// step; an ack also rotates the retired acknowledged head slots round before its report.
// Resend results leave at most one per cycle during the rotation, the final one after it.
// Reset opens all slots, clears the ack count and sets the last sequence to 65533.
// Results cannot be held off; command 3 is accepted and ignored.
`default_nettype none

module arq_send_window_tracker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  aswt_pkg::t_cmd     i_command,
    input  aswt_pkg::t_seq     i_seq_number,
    input  wire                i_final_packet,
    output logic               o_valid,
    output aswt_pkg::t_kind    o_kind,
    output aswt_pkg::t_seq     o_seq_out,
    output logic               o_all_acked,
    output logic               o_last
);
    import aswt_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_PASS, ST_ALIGN, ST_REPORT} t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DROP_W-1:0] r_drop, n_drop;
    t_cmd              r_cmd, n_cmd;
    t_seq              r_seq, n_seq;
    logic              r_fin, n_fin;
    logic              r_placed, n_placed;
    logic              r_lead, n_lead;
    logic              r_pend_valid, n_pend_valid;
    t_seq              r_pend_seq, n_pend_seq;
    t_seq              r_ack_count, n_ack_count;
    t_seq              r_last_seq, n_last_seq;
    logic              n_valid, n_all_acked, n_last;
    t_kind             n_kind;
    t_seq              n_seq_out;

    t_seq              w_slot [WINDOW_SLOTS];
    t_seq              w_tail;
    t_seq              w_marked;
    logic              w_shift;
    logic              w_seq_ok;
    logic              w_head_out;

    // Slot chain: each cell takes its neighbour, the last cell takes the processed head
    for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_cell
        if (g == WINDOW_SLOTS - 1) begin : g_last
            aswt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_tail),
                .o_slot  (w_slot[g])
            );
        end else begin : g_mid
            aswt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_slot[g+1]),
                .o_slot  (w_slot[g])
            );
        end
    end

    assign w_shift    = (r_state == ST_PASS) || (r_state == ST_ALIGN);
    assign w_seq_ok   = (r_seq < SLOT_ACKED);
    assign w_head_out = (w_slot[0] != SLOT_OPEN) && (w_slot[0] != SLOT_ACKED);
    assign w_marked   = (w_seq_ok && (w_slot[0] == r_seq)) ? SLOT_ACKED : w_slot[0];
    assign busy       = (r_state != ST_IDLE);

    // Sequencer and head processing
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_drop       = r_drop;
        n_cmd        = r_cmd;
        n_seq        = r_seq;
        n_fin        = r_fin;
        n_placed     = r_placed;
        n_lead       = r_lead;
        n_pend_valid = r_pend_valid;
        n_pend_seq   = r_pend_seq;
        n_ack_count  = r_ack_count;
        n_last_seq   = r_last_seq;
        w_tail       = w_slot[0];
        n_valid      = 1'b0;
        n_kind       = KIND_SENT;
        n_seq_out    = r_seq;
        n_all_acked  = (r_ack_count > r_last_seq);
        n_last       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start && (i_command != CMD_NONE)) begin
                    n_state      = ST_PASS;
                    n_cnt        = '0;
                    n_drop       = '0;
                    n_cmd        = i_command;
                    n_seq        = i_seq_number;
                    n_fin        = i_final_packet;
                    n_placed     = 1'b0;
                    n_lead       = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end

            ST_PASS: begin
                case (r_cmd)
                    CMD_SEND: begin
                        // First open slot takes the sequence
                        if (!r_placed && w_seq_ok && (w_slot[0] == SLOT_OPEN)) begin
                            w_tail   = r_seq;
                            n_placed = 1'b1;
                        end
                    end
                    CMD_ACK: begin
                        // Mark and count a match, retire leading acknowledged slots
                        if ((w_marked == SLOT_ACKED) && (w_slot[0] != SLOT_ACKED)
                            && (r_ack_count != ACK_MAX)) begin
                            n_ack_count = r_ack_count + 16'd1;
                        end
                        if (r_lead && (w_marked == SLOT_ACKED)) begin
                            w_tail = SLOT_OPEN;
                            n_drop = r_drop + DROP_W'(1);
                        end else begin
                            n_lead = 1'b0;
                            w_tail = w_marked;
                        end
                    end
                    CMD_TICK: begin
                        // Hold one resend back so the final one can be flagged
                        if (w_head_out) begin
                            if (r_pend_valid) begin
                                n_valid   = 1'b1;
                                n_kind    = KIND_RESEND;
                                n_seq_out = r_pend_seq;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_seq   = w_slot[0];
                        end
                    end
                    default: begin
                    end
                endcase
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WINDOW_SLOTS - 1)) begin
                    n_cnt   = '0;
                    n_state = (n_drop != '0) ? ST_ALIGN : ST_REPORT;
                end
            end

            ST_ALIGN: begin
                // Rotate the opened slots round to the tail
                n_drop = r_drop - DROP_W'(1);
                if (r_drop == DROP_W'(1)) begin
                    n_state = ST_REPORT;
                end
            end

            ST_REPORT: begin
                n_state = ST_IDLE;
                n_last  = 1'b1;
                case (r_cmd)
                    CMD_SEND: begin
                        if (r_placed && r_fin) begin
                            n_last_seq = r_seq;
                        end
                        n_valid = 1'b1;
                        n_kind  = (r_placed || !w_seq_ok) ? KIND_SENT : KIND_FULL;
                    end
                    CMD_ACK: begin
                        n_valid = 1'b1;
                        n_kind  = KIND_ACKED;
                    end
                    CMD_TICK: begin
                        n_valid   = r_pend_valid;
                        n_kind    = KIND_RESEND;
                        n_seq_out = r_pend_seq;
                    end
                    default: begin
                    end
                endcase
                n_all_acked = (r_ack_count > n_last_seq);
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ack_count  <= '0;
            r_last_seq   <= LAST_SEQ_RESET;
            r_pend_valid <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ack_count  <= n_ack_count;
            r_last_seq   <= n_last_seq;
            r_pend_valid <= n_pend_valid;
            o_valid      <= n_valid;
        end
        r_cnt       <= n_cnt;
        r_drop      <= n_drop;
        r_cmd       <= n_cmd;
        r_seq       <= n_seq;
        r_fin       <= n_fin;
        r_placed    <= n_placed;
        r_lead      <= n_lead;
        r_pend_seq  <= n_pend_seq;
        o_kind      <= n_kind;
        o_seq_out   <= n_seq_out;
        o_all_acked <= n_all_acked;
        o_last      <= n_last;
    end

`ifndef SYNTHESIS
    // Retiring head slots only happens on an ack
    a_align_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALIGN) |-> (r_cmd == CMD_ACK))
        else $error("head retire outside an ack");

    // Only resends may come as a run; every other result is the final one
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind != KIND_RESEND)) |-> o_last)
        else $error("single result without final flag");

    // Nothing follows the final result of a request
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result after final result");

    // A send or ack request always keeps the block busy for its pass
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_command == CMD_SEND) || (i_command == CMD_ACK)))
        |=> (busy && (r_state == ST_PASS)))
        else $error("request not taken into the pass");
`endif

endmodule

`default_nettype wire
